// File: hw/rtl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the job type passed from front to back, status codes and the byte encoder.
// No dependencies.
package u16u8_pkg;

    localparam logic       KIND_DATA = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    typedef struct packed {
        logic        is_end;
        logic        fail;
        logic [20:0] cp;
        logic [1:0]  lm1;
    } t_job;

    function automatic logic [7:0] f_utf8_byte(input logic [20:0] cp, input logic [1:0] lm1,
                                               input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (lm1)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                unique case (idx)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_3: begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/utf16_to_utf8_transcoder.sv
// UTF-16 byte stream to UTF-8 byte stream transcoder, top level.
// Instantiates u16u8_front, u16u8_fifo and u16u8_back; depends on u16u8_pkg.
//
// Input bytes are taken one per cycle while the job queue (QDEPTH entries) has
// room; each accepted byte is classified in that cycle. The back end sends one
// output byte per cycle while the output is not stalled: two input bytes give
// one to three output bytes (four for a surrogate pair spread over four input
// bytes). The input keeps up one byte per cycle for one- and two-byte characters
// and surrogate pairs while the output is not stalled, and falls behind for
// three-byte characters, limited by the single-byte output register.
// tuser on the input is the end marker; tuser on the output is the status
// (0 data, 1 end ok, 2 end failed) and tlast marks the last byte of a run.
module utf16_to_utf8_transcoder #(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,       // big_endian
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tuser,   // [0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] utf8_byte
    output logic       o_m_axis_tlast,
    output logic [1:0] o_m_axis_tuser    // [1:0] status
);
    import u16u8_pkg::*;

    logic full, empty, push, pop, accept;
    t_job job_in, head;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ~full;
    assign accept          = i_s_axis_tvalid & ~full;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .o_push      (push),
        .o_job       (job_in)
    );

    u16u8_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

// File: hw/rtl/u16u8_front.sv
// Front end: pairs input bytes into code units, joins surrogates, tracks errors.
// Produces one job per code point or end marker. Depends on u16u8_pkg.
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output u16u8_pkg::t_job   o_job
);
    import u16u8_pkg::*;

    logic       r_big_endian;
    logic       r_odd, n_odd;
    logic [7:0] r_held, n_held;
    logic       r_pend, n_pend;
    logic [9:0] r_hi, n_hi;
    logic       r_err, n_err;
    logic       r_seen, n_seen;
    logic [15:0] unit;
    logic        unit_hi, unit_lo;

    assign unit    = r_big_endian ? {r_held, i_byte} : {i_byte, r_held};
    assign unit_hi = (unit[15:10] == 6'b110110);
    assign unit_lo = (unit[15:10] == 6'b110111);

    always_comb begin
        n_odd  = r_odd;
        n_held = r_held;
        n_pend = r_pend;
        n_hi   = r_hi;
        n_err  = r_err;
        n_seen = r_seen;
        o_push = 1'b0;
        o_job  = '0;
        if (i_accept) begin
            if (i_kind == KIND_END) begin
                o_push     = 1'b1;
                o_job.is_end = 1'b1;
                o_job.fail = r_err | r_odd | r_pend | ~r_seen;
                n_odd  = 1'b0;
                n_held = 8'h00;
                n_pend = 1'b0;
                n_hi   = 10'h000;
                n_err  = 1'b0;
                n_seen = 1'b0;
            end else begin
                n_seen = 1'b1;
                if (!r_err) begin
                    if (!r_odd) begin
                        n_held = i_byte;
                        n_odd  = 1'b1;
                    end else begin
                        n_odd = 1'b0;
                        if (r_pend) begin
                            n_pend = 1'b0;
                            if (unit_lo) begin
                                o_push    = 1'b1;
                                o_job.cp  = 21'({r_hi, unit[9:0]}) + 21'h10000;
                                o_job.lm1 = LEN_4;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if (unit_hi) begin
                            n_pend = 1'b1;
                            n_hi   = unit[9:0];
                        end else if (unit_lo) begin
                            n_err = 1'b1;
                        end else begin
                            o_push   = 1'b1;
                            o_job.cp = 21'(unit);
                            if (unit[15:7] == 9'h000) begin
                                o_job.lm1 = LEN_1;
                            end else if (unit[15:11] == 5'h00) begin
                                o_job.lm1 = LEN_2;
                            end else begin
                                o_job.lm1 = LEN_3;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_odd  <= 1'b0;
            r_held <= 8'h00;
            r_pend <= 1'b0;
            r_hi   <= 10'h000;
            r_err  <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_big_endian <= i_cfg_data;
            end
            r_odd  <= n_odd;
            r_held <= n_held;
            r_pend <= n_pend;
            r_hi   <= n_hi;
            r_err  <= n_err;
            r_seen <= n_seen;
        end
    end

endmodule

// File: hw/rtl/u16u8_fifo.sv
// Short job queue between front and back.
// Depends on u16u8_pkg for the job type.
module u16u8_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16u8_pkg::t_job i_job,
    input  logic            i_pop,
    output u16u8_pkg::t_job o_head,
    output logic            o_full,
    output logic            o_empty
);
    import u16u8_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/u16u8_back.sv
// Back end: expands each job into UTF-8 bytes or one end record, one per cycle while the output is not stalled.
// Drives the registered output stream. Depends on u16u8_pkg.
module u16u8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u16u8_pkg::t_job i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast,
    output logic [1:0]      o_tuser
);
    import u16u8_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic [1:0] r_ostat;
    t_job       cur;
    logic [1:0] idx;
    logic       out_free, have_job, last;

    assign out_free = ~r_ovalid | i_tready;
    assign have_job = r_busy | ~i_empty;
    assign cur      = r_busy ? r_job : i_head;
    assign idx      = r_busy ? r_idx : 2'd0;
    assign last     = cur.is_end | (idx == cur.lm1);
    assign o_pop    = out_free & ~r_busy & ~i_empty;

    always_ff @(posedge i_clk) begin
        if (out_free && have_job) begin
            r_job   <= cur;
            r_idx   <= idx + 2'd1;
            r_obyte <= cur.is_end ? 8'h00 : f_utf8_byte(cur.cp, cur.lm1, idx);
            r_olast <= last;
            r_ostat <= cur.is_end ? (cur.fail ? ST_FAIL : ST_OK) : ST_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= have_job;
            r_busy   <= have_job & ~last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obyte;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_ostat;

endmodule

// File: hw/rtl/u16u8_checker.sv
// Port-level checks for the transcoder output stream, bound to the top level.
// Depends on u16u8_pkg for status codes.
module u16u8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [1:0] o_m_axis_tuser
);
    import u16u8_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_DATA |->
            o_m_axis_tdata == 8'h00 && o_m_axis_tlast
            && (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_FAIL))
        else $error("malformed end record");

    a_multi_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_DATA && !o_m_axis_tlast |->
            o_m_axis_tdata[7])
        else $error("non-final byte is not part of a multi-byte sequence");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser == ST_DATA
            && !o_m_axis_tlast |=> o_m_axis_tvalid && o_m_axis_tuser == ST_DATA
            && o_m_axis_tdata[7:6] == 2'b10)
        else $error("multi-byte sequence broken");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);

// File: sim/tb_top.sv
// Testbench for utf16_to_utf8_transcoder: directed, back-pressure and random UTF-16 streams.
// Predicts the UTF-8 output per accepted byte and checks every output transaction.
// Depends on u16u8_pkg and the transcoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [15:0] SURR_MASK      = 16'hFC00;
    localparam logic [15:0] HIGH_SURR      = 16'hD800;
    localparam logic [15:0] LOW_SURR       = 16'hDC00;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    typedef struct packed {
        logic [7:0] utf8;
        logic       last;
        logic [1:0] status;
    } t_utf8_beat;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data      = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       i_s_axis_tuser  = 1'b0;    // [0] kind
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] utf8_byte
    logic       o_m_axis_tlast;
    logic [1:0] o_m_axis_tuser;            // [1:0] status

    utf16_to_utf8_transcoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // predictor state
    logic        byte_order_be;
    logic        half_held;
    logic [7:0]  first_byte;
    logic        hi_pending;
    logic [9:0]  hi_bits;
    logic        decode_err;
    logic        got_data;

    t_utf8_beat  utf8_expected[$];
    t_utf8_beat  got_beat;
    logic        in_fire  = 1'b0;
    logic        out_fire = 1'b0;
    logic        cfg_fire = 1'b0;

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;
    int stream_items   = 0;
    int frames_closed  = 0;
    int utf8_checked   = 0;
    int cfg_writes     = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_decoder();
        half_held  = 1'b0;
        first_byte = 8'h00;
        hi_pending = 1'b0;
        hi_bits    = 10'd0;
        decode_err = 1'b0;
        got_data   = 1'b0;
    endfunction

    function automatic void queue_beat(input t_utf8_beat beat);
        utf8_expected = {utf8_expected, beat};
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic last);
        queue_beat('{utf8: b, last: last, status: ST_DATA});
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_beat(cp[7:0], 1'b1);
        end else if (cp < 21'h800) begin
            push_beat(8'hC0 | 8'(cp >> 6), 1'b0);
            push_beat(8'h80 | 8'(cp & 21'h3F), 1'b1);
        end else if (cp < SUPP_BASE) begin
            push_beat(8'hE0 | 8'(cp >> 12), 1'b0);
            push_beat(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
            push_beat(8'h80 | 8'(cp & 21'h3F), 1'b1);
        end else begin
            push_beat(8'hF0 | 8'((cp >> 18) & 21'h07), 1'b0);
            push_beat(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b0);
            push_beat(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
            push_beat(8'h80 | 8'(cp & 21'h3F), 1'b1);
        end
    endfunction

    function automatic void transcode_model(input logic kind, input logic [7:0] data);
        logic [15:0] unit;
        logic        fail;
        if (kind == KIND_END) begin
            fail = decode_err || half_held || hi_pending || !got_data;
            queue_beat('{utf8: 8'h00, last: 1'b1, status: fail ? ST_FAIL : ST_OK});
            frames_closed++;
            clear_decoder();
            return;
        end
        got_data = 1'b1;
        if (decode_err)
            return;
        if (!half_held) begin
            first_byte = data;
            half_held  = 1'b1;
            return;
        end
        half_held = 1'b0;
        unit = byte_order_be ? {first_byte, data} : {data, first_byte};
        if (hi_pending) begin
            hi_pending = 1'b0;
            if ((unit & SURR_MASK) != LOW_SURR)
                decode_err = 1'b1;
            else
                push_utf8({1'b0, hi_bits, unit[9:0]} + SUPP_BASE);
        end else if ((unit & SURR_MASK) == HIGH_SURR) begin
            hi_pending = 1'b1;
            hi_bits    = unit[9:0];
        end else if ((unit & SURR_MASK) == LOW_SURR) begin
            decode_err = 1'b1;
        end else begin
            push_utf8({5'd0, unit});
        end
    endfunction

    // sample handshakes mid-cycle, where nothing moves until the next rising edge
    always @(negedge i_clk) begin
        in_fire  = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_fire = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        got_beat = {o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser};
    end

    always @(posedge i_clk) begin : utf8_checker
        t_utf8_beat want;
        if (out_fire) begin
            if (utf8_expected.size() == 0) begin
                $display("%0t unexpected output: byte %h last %b status %0d", $time,
                         got_beat.utf8, got_beat.last, got_beat.status);
                mismatches++;
            end else begin
                want = utf8_expected.pop_front();
                utf8_checked++;
                if (want.utf8 !== got_beat.utf8 || want.last !== got_beat.last ||
                    want.status !== got_beat.status) begin
                    $display("%0t mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                             $time, want.utf8, want.last, want.status,
                             got_beat.utf8, got_beat.last, got_beat.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx_ready
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire || cfg_fire || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, utf8_expected.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        @(negedge i_clk);
        while (!o_s_axis_tready)
            @(negedge i_clk);
        transcode_model(kind, data);
        stream_items++;
        @(posedge i_clk);
    endtask

    task automatic send_unit(input logic [15:0] unit);
        if (byte_order_be) begin
            send_item(KIND_DATA, unit[15:8]);
            send_item(KIND_DATA, unit[7:0]);
        end else begin
            send_item(KIND_DATA, unit[7:0]);
            send_item(KIND_DATA, unit[15:8]);
        end
    endtask

    task automatic send_code_point(input logic [20:0] cp);
        logic [19:0] v;
        if (cp >= SUPP_BASE) begin
            v = 20'(cp - SUPP_BASE);
            send_unit(HIGH_SURR | {6'd0, v[19:10]});
            send_unit(LOW_SURR | {6'd0, v[9:0]});
        end else begin
            send_unit(cp[15:0]);
        end
    endtask

    task automatic drain_outputs();
        i_s_axis_tvalid <= 1'b0;
        while (utf8_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_byte_order(input logic be);
        drain_outputs();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= be;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        byte_order_be = be;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [20:0] random_code_point();
        unique case ($urandom_range(3))
            0:       return 21'($urandom_range(8'h7F));
            1:       return 21'($urandom_range(12'h7FF, 8'h80));
            2:       return $urandom_range(1) ? 21'($urandom_range(16'hD7FF, 16'h0800))
                                              : 21'($urandom_range(16'hFFFF, 16'hE000));
            default: return 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
    endfunction

    // mostly well-formed frames, some with a decoding fault, some empty, some plain noise
    task automatic send_random_frame();
        int fault;
        int n;
        fault = $urandom_range(99);
        n     = $urandom_range(1, 6);
        if (fault >= 88) begin
            repeat ($urandom_range(1, 8)) send_item(KIND_DATA, 8'($urandom));
        end else if (fault < 85) begin
            for (int i = 0; i < n; i++) begin
                if (fault >= 70 && fault < 75 && i == n / 2) begin
                    send_unit(LOW_SURR | 16'($urandom_range(10'h3FF)));
                end else if (fault >= 75 && fault < 80 && i == n / 2) begin
                    send_unit(HIGH_SURR | 16'($urandom_range(10'h3FF)));
                    send_code_point(random_code_point());
                end
                send_code_point(random_code_point());
            end
            if (fault >= 80)
                send_item(KIND_DATA, 8'($urandom));
        end
        send_item(KIND_END, 8'($urandom));
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 21;
        rx_idle_pct = 67;
        write_byte_order(1'b0);
        send_unit(16'h007F);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hFFFF);
        send_code_point(21'h10000);
        send_code_point(21'h10FFFF);
        send_item(KIND_END, 8'h00);
        // unpaired high surrogate, then a byte after the error
        send_unit(16'hD800);
        send_unit(16'h0041);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_END, 8'hFF);
        // lone low surrogate
        send_unit(16'hDC00);
        send_item(KIND_END, 8'h00);
        // odd byte count, then an empty stream
        send_item(KIND_DATA, 8'h41);
        send_item(KIND_END, 8'h00);
        send_item(KIND_END, 8'h00);
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 300;
        repeat (24) send_unit(16'($urandom_range(16'hD7FF, 16'h0800)));
        send_item(KIND_END, 8'h00);
    endtask

    task automatic run_random_phase(input int count, input logic be, input int tx,
                                    input int rx);
        int start;
        write_byte_order(be);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        start = stream_items;
        while (stream_items - start < count)
            send_random_frame();
    endtask

    task automatic test_random_traffic();
        run_random_phase(150, 1'b1, 21, 67);
        run_random_phase(150, 1'b0, 67, 21);
        run_random_phase(60, 1'b1, 0, 0);
        run_random_phase(60, 1'b0, 0, 0);
    endtask

    initial begin
        byte_order_be = 1'b0;
        clear_decoder();
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        drain_outputs();
        repeat (30) @(posedge i_clk);
        $display("run covered %0d stream bytes and markers in %0d frames",
                 stream_items, frames_closed);
        $display("%0d output bytes checked, both byte orders over %0d register writes",
                 utf8_checked, cfg_writes);
        if (mismatches == 0 && utf8_expected.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
